FILE: design/sgdt_pkg.sv
// Shared types and constants for the Sobel gradient double-threshold unit.
package sgdt_pkg;

  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;
  localparam int MAG_W   = 11;
  localparam int SQ_W    = 22;
  localparam int CLASS_W = 2;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int ROOT_CNT_W = 4;

  localparam logic [CIDX_W-1:0] REG_LOW    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HIGH   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic [10:0] LOW_RESET    = 11'd20;
  localparam logic [10:0] HIGH_RESET   = 11'd90;
  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd768;
  localparam logic [10:0] LOW_DEFAULT  = 11'd20;
  localparam logic [10:0] HIGH_DEFAULT = 11'd90;

  localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic square;
    logic root_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;
    logic root_last;
    logic out_free;
  } sts_t;

endpackage

FILE: design/sgdt_ctrl.sv
// Sequencing state machine for the Sobel gradient double-threshold unit.
module sgdt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sgdt_pkg::sts_t sts,
  output sgdt_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CALC   = 5'b00010,
    S_SQUARE = 5'b00100,
    S_ROOT   = 5'b01000,
    S_WAIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = sts.emit ? S_SQUARE : S_IDLE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/sgdt_datapath.sv
// Datapath: config registers, line buffers, window, gradients, root and output register.
module sgdt_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sgdt_pkg::cmd_t                        cmd,
  output sgdt_pkg::sts_t                        sts,
  input  logic                                  cfg_write_enable,
  input  logic [sgdt_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [sgdt_pkg::CFG_W-1:0]            cfg_data,
  input  logic [sgdt_pkg::PIX_W-1:0]            red,
  input  logic [sgdt_pkg::PIX_W-1:0]            green,
  input  logic [sgdt_pkg::PIX_W-1:0]            blue,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sgdt_pkg::GRAD_W-1:0]    grad_x,
  output logic signed [sgdt_pkg::GRAD_W-1:0]    grad_y,
  output logic [sgdt_pkg::MAG_W-1:0]            grad_magnitude,
  output logic [sgdt_pkg::CLASS_W-1:0]          edge_class,
  output logic                                  frame_end
);

  localparam int CA = $clog2(MAX_WIDTH);
  localparam int RA = $clog2(MAX_HEIGHT);
  localparam int LW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int HW = ($clog2(MAX_HEIGHT + 1) > 13) ? $clog2(MAX_HEIGHT + 1) : 13;
  localparam int P  = sgdt_pkg::PIX_W;

  // configuration
  logic [10:0] low_threshold, high_threshold, frame_width;
  logic [12:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= sgdt_pkg::LOW_RESET;
      high_threshold <= sgdt_pkg::HIGH_RESET;
      frame_width    <= sgdt_pkg::WIDTH_RESET;
      frame_height   <= sgdt_pkg::HEIGHT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        sgdt_pkg::REG_LOW:    low_threshold  <= cfg_data[10:0];
        sgdt_pkg::REG_HIGH:   high_threshold <= cfg_data[10:0];
        sgdt_pkg::REG_WIDTH:  frame_width    <= cfg_data[10:0];
        sgdt_pkg::REG_HEIGHT: frame_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // width and height in use, saturated
  logic [LW-1:0] w_use, fw_ext;
  logic [HW-1:0] h_use, fh_ext;

  always_comb begin
    fw_ext = LW'(frame_width);
    fh_ext = HW'(frame_height);
    if (fw_ext < LW'(3))              w_use = LW'(3);
    else if (fw_ext > LW'(MAX_WIDTH)) w_use = LW'(MAX_WIDTH);
    else                              w_use = fw_ext;
    if (fh_ext < HW'(3))               h_use = HW'(3);
    else if (fh_ext > HW'(MAX_HEIGHT)) h_use = HW'(MAX_HEIGHT);
    else                               h_use = fh_ext;
  end

  // position counters, wrapped before the pixel is taken
  logic [CA-1:0] column_count, column_next, c_eff, c_cur;
  logic [RA-1:0] row_count, row_next, r_eff, r_cur;
  logic [HW-1:0] r_pre;

  always_comb begin
    if (LW'(column_count) >= w_use) begin
      c_eff = '0;
      r_pre = HW'(row_count) + HW'(1);
    end else begin
      c_eff = column_count;
      r_pre = HW'(row_count);
    end
    r_eff = (r_pre >= h_use) ? '0 : r_pre[RA-1:0];
  end

  logic [LW-1:0] c_inc;
  logic [HW-1:0] r_inc;

  always_comb begin
    c_inc       = LW'(c_cur) + LW'(1);
    r_inc       = HW'(r_cur) + HW'(1);
    column_next = c_inc[CA-1:0];
    row_next    = r_cur;
    if (c_inc >= w_use) begin
      column_next = '0;
      row_next    = (r_inc >= h_use) ? '0 : r_inc[RA-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.calc) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  // intensity: floor(sum/3) by reciprocal, exact for sums below 2048
  logic [9:0]  rgb_sum;
  logic [20:0] gray_prod;
  logic [P-1:0] gray;

  always_comb begin
    rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
    gray_prod = 21'(rgb_sum) * 21'd683;
  end

  // line buffers
  logic [P-1:0] older_line [MAX_WIDTH];
  logic [P-1:0] newer_line [MAX_WIDTH];
  logic [P-1:0] top, mid;
  logic [P-1:0] win [6];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      top   <= older_line[c_eff];
      mid   <= newer_line[c_eff];
      gray  <= gray_prod[18:11];
      c_cur <= c_eff;
      r_cur <= r_eff;
    end
    if (cmd.calc) begin
      older_line[c_cur] <= mid;
      newer_line[c_cur] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= gray;
    end
  end

  // gradients
  logic [9:0] sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [sgdt_pkg::GRAD_W-1:0] gx_c, gy_c, gx, gy;
  logic full_window, emit_c, fend_c, fend;

  always_comb begin
    sx_pos = 10'(top) + {1'b0, mid, 1'b0} + 10'(gray);
    sx_neg = 10'(win[0]) + {1'b0, win[1], 1'b0} + 10'(win[2]);
    sy_pos = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(gray);
    sy_neg = 10'(win[0]) + {1'b0, win[3], 1'b0} + 10'(top);
    full_window = (r_cur >= RA'(2)) && (c_cur >= CA'(2));
    gx_c = full_window ? ($signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg})) : '0;
    gy_c = full_window ? ($signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg})) : '0;
    emit_c = (r_cur != '0) && (c_cur != '0);
    fend_c = (HW'(r_cur) == h_use - HW'(1)) && (LW'(c_cur) == w_use - LW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gx   <= gx_c;
      gy   <= gy_c;
      fend <= fend_c;
    end
  end

  // square sum and bitwise root, one result bit per cycle
  logic [sgdt_pkg::SQ_W-1:0] sq;
  logic signed [sgdt_pkg::SQ_W-1:0] gx_sq, gy_sq;
  logic [sgdt_pkg::MAG_W-1:0] root, trial;
  logic [sgdt_pkg::SQ_W-1:0] trial_sq;
  logic [sgdt_pkg::ROOT_CNT_W-1:0] root_bit;

  function automatic logic signed [sgdt_pkg::SQ_W-1:0] SQ_W_EXT(
    input logic signed [sgdt_pkg::GRAD_W-1:0] v);
    return sgdt_pkg::SQ_W'(v);
  endfunction

  always_comb begin
    gx_sq    = SQ_W_EXT(gx) * SQ_W_EXT(gx);
    gy_sq    = SQ_W_EXT(gy) * SQ_W_EXT(gy);
    trial    = root | (sgdt_pkg::MAG_W'(1) << root_bit);
    trial_sq = sgdt_pkg::SQ_W'(trial) * sgdt_pkg::SQ_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq       <= sgdt_pkg::SQ_W'(gx_sq) + sgdt_pkg::SQ_W'(gy_sq);
      root     <= '0;
      root_bit <= sgdt_pkg::ROOT_CNT_W'(sgdt_pkg::MAG_W - 1);
    end else if (cmd.root_step) begin
      if (trial_sq <= sq) root <= trial;
      root_bit <= root_bit - sgdt_pkg::ROOT_CNT_W'(1);
    end
  end

  // classification and output register
  logic [10:0] lo_use, hi_use;
  logic [sgdt_pkg::CLASS_W-1:0] class_c;

  always_comb begin
    lo_use = low_threshold;
    hi_use = high_threshold;
    if (low_threshold == '0 && high_threshold == '0) begin
      lo_use = sgdt_pkg::LOW_DEFAULT;
      hi_use = sgdt_pkg::HIGH_DEFAULT;
    end
    if (root < lo_use)      class_c = sgdt_pkg::CLASS_NONE;
    else if (root < hi_use) class_c = sgdt_pkg::CLASS_WEAK;
    else                    class_c = sgdt_pkg::CLASS_STRONG;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      grad_x         <= gx;
      grad_y         <= gy;
      grad_magnitude <= root;
      edge_class     <= class_c;
      frame_end      <= fend;
    end
  end

  assign sts.emit      = emit_c;
  assign sts.root_last = (root_bit == '0);
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

FILE: design/sobel_gradient_double_threshold_unit.sv
// Top level of the streaming Sobel gradient magnitude and double-threshold unit.
//
// Input channel: red/green/blue pixel items in raster order, taken on
// in_valid && !in_stall. Output channel: grad_x, grad_y, grad_magnitude,
// edge_class and frame_end, presented on out_valid and held while out_stall.
// Each pixel yields the result for the centre one row up and one column left;
// the first row and first column of every row yield no result.
// Steps: every pixel is read from the line buffers, then updates the window
// and registers its gradients. A pixel with a result then goes through the
// squares and the bitwise square root (one result bit per cycle), then the
// output load. A new pixel is taken only once the unit is back in idle, so
// throughput is set by the serial root unit.
// The output register is separate, so the next pixel is taken while a result
// waits; a second result waits inside until the register frees up.
// Synchronous reset clears position counters, output valid and loads the
// register reset values; line buffers and window are not cleared.
// Configuration writes (cfg_write_enable, cfg_index, cfg_data) are registered
// and should be made only while the unit is idle.
module sobel_gradient_double_threshold_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sgdt_pkg::PIX_W-1:0]          red,
  input  logic [sgdt_pkg::PIX_W-1:0]          green,
  input  logic [sgdt_pkg::PIX_W-1:0]          blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sgdt_pkg::GRAD_W-1:0]  grad_x,
  output logic signed [sgdt_pkg::GRAD_W-1:0]  grad_y,
  output logic [sgdt_pkg::MAG_W-1:0]          grad_magnitude,
  output logic [sgdt_pkg::CLASS_W-1:0]        edge_class,
  output logic                                frame_end,
  input  logic                                cfg_write_enable,
  input  logic [sgdt_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [sgdt_pkg::CFG_W-1:0]          cfg_data
);

  sgdt_pkg::cmd_t cmd;
  sgdt_pkg::sts_t sts;

  sgdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgdt_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .grad_x           (grad_x),
    .grad_y           (grad_y),
    .grad_magnitude   (grad_magnitude),
    .edge_class       (edge_class),
    .frame_end        (frame_end)
  );

endmodule

FILE: tb/sv/sobel_edge_checker.sv
// Checker for the Sobel gradient unit: predicts each result from accepted pixels and compares.
module sobel_edge_checker
  import sgdt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [PIX_W-1:0]          red,
  input  logic [PIX_W-1:0]          green,
  input  logic [PIX_W-1:0]          blue,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [GRAD_W-1:0]  grad_x,
  input  logic signed [GRAD_W-1:0]  grad_y,
  input  logic [MAG_W-1:0]          grad_magnitude,
  input  logic [CLASS_W-1:0]        edge_class,
  input  logic                      frame_end,
  input  logic                      cfg_write_enable,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        pending_count,
  output int                        result_count
);

  localparam int LINE_DEPTH = 1024;
  localparam int ROWS_MAX   = 4096;

  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic [CLASS_W-1:0]       cls;
    logic                     last;
  } edge_result_t;

  edge_result_t expected_results[$];

  logic [10:0] thr_low, thr_high, width_reg;
  logic [12:0] height_reg;
  logic [7:0]  line_two_up[LINE_DEPTH];
  logic [7:0]  line_one_up[LINE_DEPTH];
  logic [7:0]  win[6];  // 0..2 column c-2 top/mid/bot, 3..5 column c-1
  int          col, row;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor of square root by counting up; inputs stay below 2.1 million
  function automatic int floor_root(int v);
    int m;
    m = 0;
    while ((m + 1) * (m + 1) <= v) m++;
    return m;
  endfunction

  task automatic take_pixel(input logic [7:0] r8, input logic [7:0] g8, input logic [7:0] b8);
    int w, h, gray, top, mid, gx, gy, mag, lo, hi;
    edge_result_t res;
    w = clip(width_reg, 3, LINE_DEPTH);
    h = clip(height_reg, 3, ROWS_MAX);
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    gray = (int'(r8) + int'(g8) + int'(b8)) / 3;
    top = line_two_up[col];
    mid = line_one_up[col];
    if (row >= 1 && col >= 1) begin
      gx = 0;
      gy = 0;
      if (row >= 2 && col >= 2) begin
        gx = (top + 2 * mid + gray) - (win[0] + 2 * win[1] + win[2]);
        gy = (win[2] + 2 * win[5] + gray) - (win[0] + 2 * win[3] + top);
      end
      mag = floor_root(gx * gx + gy * gy);
      lo = thr_low;
      hi = thr_high;
      if (lo == 0 && hi == 0) begin
        lo = LOW_DEFAULT;
        hi = HIGH_DEFAULT;
      end
      res.gx   = gx[GRAD_W-1:0];
      res.gy   = gy[GRAD_W-1:0];
      res.mag  = mag[MAG_W-1:0];
      res.cls  = (mag < lo) ? CLASS_NONE : ((mag < hi) ? CLASS_WEAK : CLASS_STRONG);
      res.last = (row == h - 1) && (col == w - 1);
      expected_results.push_back(res);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top[7:0];
    win[4] = mid[7:0];
    win[5] = gray[7:0];
    line_two_up[col] = mid[7:0];
    line_one_up[col] = gray[7:0];
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      thr_low    = LOW_RESET;
      thr_high   = HIGH_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col = 0;
      row = 0;
      foreach (line_two_up[i]) line_two_up[i] = '0;
      foreach (line_one_up[i]) line_one_up[i] = '0;
      foreach (win[i]) win[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_LOW:    thr_low    = cfg_data[10:0];
          REG_HIGH:   thr_high   = cfg_data[10:0];
          REG_WIDTH:  width_reg  = cfg_data[10:0];
          REG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result item: grad_x %0d grad_y %0d", grad_x, grad_y);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (grad_x !== want.gx) begin
            $error("grad_x: expected %0d, got %0d", want.gx, grad_x);
            fail_count++;
          end
          if (grad_y !== want.gy) begin
            $error("grad_y: expected %0d, got %0d", want.gy, grad_y);
            fail_count++;
          end
          if (grad_magnitude !== want.mag) begin
            $error("grad_magnitude: expected %0d, got %0d", want.mag, grad_magnitude);
            fail_count++;
          end
          if (edge_class !== want.cls) begin
            $error("edge_class: expected %0d, got %0d", want.cls, edge_class);
            fail_count++;
          end
          if (frame_end !== want.last) begin
            $error("frame_end: expected %0d, got %0d", want.last, frame_end);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_pixel(red, green, blue);
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: tb/sv/sobel_gradient_double_threshold_unit_tb.sv
// Testbench top for the Sobel gradient unit: pixel stimulus, config phases and verdict.
module sobel_gradient_double_threshold_unit_tb;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE      = 20;    // covers the result path
  localparam int DRAIN       = 30;

  logic                               clk, rst;
  logic                               in_valid, in_stall;
  logic [sgdt_pkg::PIX_W-1:0]         red, green, blue;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [sgdt_pkg::GRAD_W-1:0] grad_x, grad_y;
  logic [sgdt_pkg::MAG_W-1:0]         grad_magnitude;
  logic [sgdt_pkg::CLASS_W-1:0]       edge_class;
  logic                               frame_end;
  logic                               cfg_write_enable;
  logic [sgdt_pkg::CIDX_W-1:0]        cfg_index;
  logic [sgdt_pkg::CFG_W-1:0]         cfg_data;

  int fail_count, pending_count, result_count;
  int idle_pct, stall_pct;
  // stimulus-side copy of frame geometry and position, so phases can
  // start on a frame boundary when that matters
  int frame_w, frame_h, col_pos, row_pos;
  int pixels_sent, quiet_cycles;

  sobel_gradient_double_threshold_unit uut (
    .clk, .rst, .in_valid, .in_stall, .red, .green, .blue,
    .out_valid, .out_stall, .grad_x, .grad_y, .grad_magnitude, .edge_class,
    .frame_end, .cfg_write_enable, .cfg_index, .cfg_data
  );

  sobel_edge_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .red, .green, .blue,
    .out_valid, .out_stall, .grad_x, .grad_y, .grad_magnitude, .edge_class,
    .frame_end, .cfg_write_enable, .cfg_index, .cfg_data,
    .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: too long without any handshake or register write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d results still outstanding", pending_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // apply the same lazy wrap the unit does before taking a pixel
  task automatic wrap_position();
    if (col_pos >= clip(frame_w, 3, 1024)) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= clip(frame_h, 3, 4096)) row_pos = 0;
  endtask

  task automatic send_pixel(input int r, input int g, input int b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red      <= r[7:0];
    green    <= g[7:0];
    blue     <= b[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    wrap_position();
    col_pos++;
    pixels_sent++;
  endtask

  // half full-range noise, half small noise around a level so classes vary
  task automatic send_random_pixel(input int level);
    if ($urandom_range(1))
      send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    else
      send_pixel(clip(level + $urandom_range(15), 0, 255),
                 clip(level + $urandom_range(15), 0, 255),
                 clip(level + $urandom_range(15), 0, 255));
  endtask

  // hold off the sender until every predicted result has come out
  task automatic wait_drained(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sgdt_pkg::CIDX_W-1:0] idx, input int value);
    wait_drained(SETTLE);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value[sgdt_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    if (idx == sgdt_pkg::REG_WIDTH)  frame_w = value & 11'h7ff;
    if (idx == sgdt_pkg::REG_HEIGHT) frame_h = value & 13'h1fff;
  endtask

  task automatic finish_frame();
    wrap_position();
    while (col_pos != 0 || row_pos != 0) begin
      send_random_pixel(128);
      wrap_position();
    end
  endtask

  initial begin
    int lo, hi, level, v;
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    red              <= '0;
    green            <= '0;
    blue             <= '0;
    cfg_write_enable <= 1'b0;
    cfg_index        <= sgdt_pkg::REG_LOW;
    cfg_data         <= '0;
    idle_pct = 20;
    stall_pct = 82;
    frame_w = sgdt_pkg::WIDTH_RESET;
    frame_h = sgdt_pkg::HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    pixels_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Fill both line buffers across 64 columns. Later widths stay at or below
    // 64 until the widest row, so no never-written entry feeds a gradient.
    write_reg(sgdt_pkg::REG_WIDTH, 64);
    write_reg(sgdt_pkg::REG_HEIGHT, 3);
    repeat (64 * 3) send_random_pixel(100);

    // Directed 3x3 frames: full positive gx, near-full positive gy with both
    // thresholds zero (defaults apply), then a negative corner with high
    // thresholds.
    write_reg(sgdt_pkg::REG_WIDTH, 3);
    write_reg(sgdt_pkg::REG_HEIGHT, 3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (c == 2) send_pixel(255, 255, 255); else send_pixel(0, 0, 0);
    write_reg(sgdt_pkg::REG_LOW, 0);
    write_reg(sgdt_pkg::REG_HIGH, 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (r == 2) send_pixel(255, 255, 254); else send_pixel(1, 0, 0);
    write_reg(sgdt_pkg::REG_LOW, 1442);
    write_reg(sgdt_pkg::REG_HIGH, 2047);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (r == 0 || c == 0) send_pixel(255, 255, 255); else send_pixel(0, 0, 0);

    // Random phases; geometry changes land mid-frame, so rows and frames
    // get cut short. Idle mix: sender-light, receiver-light, then none.
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(5))
        0: begin lo = 0; hi = 0; end
        1: begin lo = 0; hi = 2047; end
        2: begin lo = 1442; hi = 1442; end
        3: begin hi = $urandom_range(200); lo = hi + $urandom_range(1, 300); end
        default: begin lo = $urandom_range(300); hi = lo + $urandom_range(600); end
      endcase
      write_reg(sgdt_pkg::REG_LOW, lo);
      write_reg(sgdt_pkg::REG_HIGH, hi);
      case ($urandom_range(4))
        0:       v = $urandom_range(2);
        1:       v = 64;
        default: v = $urandom_range(3, 40);
      endcase
      write_reg(sgdt_pkg::REG_WIDTH, v);
      case ($urandom_range(5))
        0:       v = 0;
        1:       v = 8191;
        2:       v = 4096;
        default: v = $urandom_range(3, 8);
      endcase
      write_reg(sgdt_pkg::REG_HEIGHT, v);
      if (p < 3) begin
        idle_pct = 20;
        stall_pct = 82;
      end else if (p < 6) begin
        idle_pct = 82;
        stall_pct = 20;
      end else begin
        idle_pct = 0;
        stall_pct = 0;
      end
      level = $urandom_range(240);
      for (int i = 0; i < 40; i++) begin
        if (p == 4 && i == 20) wait_drained(0);
        send_random_pixel(level);
      end
    end

    // Widest row, reached through an out-of-range width write that
    // saturates; the frame is cut to three rows and finished first, so it
    // starts on a frame boundary and every read line entry feeding a
    // gradient has been written.
    write_reg(sgdt_pkg::REG_HEIGHT, 3);
    finish_frame();
    write_reg(sgdt_pkg::REG_WIDTH, 2047);
    repeat (1024 + 16) send_random_pixel(60);

    wait_drained(DRAIN);
    $display("Sent %0d pixels and checked %0d results over threshold extremes,",
             pixels_sent, result_count);
    $display("widths 3 to 1024, saturated geometry and mid-frame changes.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sgdt_pkg.sv
design/sgdt_ctrl.sv
design/sgdt_datapath.sv
design/sobel_gradient_double_threshold_unit.sv
tb/sv/sobel_edge_checker.sv
tb/sv/sobel_gradient_double_threshold_unit_tb.sv
